// ----- hdl/tbpg_pkg.sv -----
// shared widths, register map and reset values of the title bar pixel generator
package tbpg_pkg;

  localparam int COL_W   = 12;
  localparam int ROW_W   = 6;
  localparam int WIDTH_W = 13;
  localparam int COLOR_W = 32;
  localparam int DIFF_W  = 15;
  localparam int MARK_W  = 9;
  localparam int ADDR_W  = 4;
  localparam int APB_W   = 32;
  localparam int IN_W    = 24;

  localparam int DEF_BAR_HEIGHT    = 24;
  localparam int DEF_CLOSE_WIDTH   = 32;
  localparam int DEF_CORNER_RADIUS = 8;
  localparam int DEF_MARK_MARGIN   = 7;

  localparam logic [1:0] REG_BAR_WIDTH    = 2'd0;
  localparam logic [1:0] REG_BAR_COLOR    = 2'd1;
  localparam logic [1:0] REG_BUTTON_COLOR = 2'd2;
  localparam logic [1:0] REG_MARK_COLOR   = 2'd3;

  localparam logic [WIDTH_W-1:0] RST_BAR_WIDTH    = 13'd640;
  localparam logic [COLOR_W-1:0] RST_BAR_COLOR    = 32'hff383838;
  localparam logic [COLOR_W-1:0] RST_BUTTON_COLOR = 32'hff802020;
  localparam logic [COLOR_W-1:0] RST_MARK_COLOR   = 32'hffe0e0e0;
  localparam logic [COLOR_W-1:0] TRANSPARENT      = 32'h00000000;

endpackage

// ----- hdl/titlebar_pixel_generator_top.sv -----
// title bar pixel generator: coordinate in, argb8888 colour out, three stage pipeline
//
// usage:
//   s_tvalid/s_tready/s_tdata carry one pixel coordinate per beat:
//     tdata[11:0] column, tdata[17:12] row, tdata[23:18] zero.
//   m_tvalid/m_tready/m_tdata carry one argb8888 pixel per beat.
//   the apb port holds bar_width (0x0), bar_color (0x4), button_color (0x8)
//   and mark_color (0xc); pready is always high. write registers only while
//   the pipeline is empty.
// an accepted coordinate passes all three stage registers, the last being m_tdata;
// one beat is taken every cycle unless a full pipeline is stalled. the stages
// are: range check and offset from the right edge, corner and close mark
// geometry, corner circle test plus colour select into the output register.
// reset empties the pipeline and restores the default bar width and colours.
// when the receiver stalls, each stage holds while the one after it is full,
// so up to three beats stay in flight and s_tready drops only once all are
// full; s_tready follows m_tready combinationally.
module titlebar_pixel_generator_top #(
  parameter int BAR_HEIGHT    = tbpg_pkg::DEF_BAR_HEIGHT,
  parameter int CLOSE_WIDTH   = tbpg_pkg::DEF_CLOSE_WIDTH,
  parameter int CORNER_RADIUS = tbpg_pkg::DEF_CORNER_RADIUS,
  parameter int MARK_MARGIN   = tbpg_pkg::DEF_MARK_MARGIN
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [tbpg_pkg::IN_W-1:0]    s_tdata,   // column, row, zero fill
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [tbpg_pkg::COLOR_W-1:0] m_tdata,   // pixel
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tbpg_pkg::ADDR_W-1:0]  paddr,
  input  logic [tbpg_pkg::APB_W-1:0]   pwdata,
  output logic [tbpg_pkg::APB_W-1:0]   prdata,
  output logic                         pready
);

  localparam int DW = tbpg_pkg::DIFF_W;
  localparam int MW = tbpg_pkg::MARK_W;
  localparam int AW = $clog2(CORNER_RADIUS + 1);
  localparam int SW = 2 * AW + 1;

  localparam logic signed [DW-1:0] NEG_R   = DW'(-CORNER_RADIUS);
  localparam logic signed [DW-1:0] R_D     = DW'(CORNER_RADIUS);
  localparam logic signed [DW-1:0] R1_D    = DW'(CORNER_RADIUS + 1);
  localparam logic signed [DW-1:0] CW_D    = DW'(CLOSE_WIDTH);
  localparam logic signed [MW-1:0] MARGIN  = MW'(MARK_MARGIN);
  localparam logic signed [MW-1:0] MEND    = MW'(CLOSE_WIDTH - MARK_MARGIN);
  localparam logic signed [MW-1:0] SPAN    = MW'(CLOSE_WIDTH - 2 * MARK_MARGIN - 1);
  localparam logic signed [MW-1:0] ONE_M   = MW'(1);
  localparam logic signed [MW-1:0] NEG1_M  = MW'(-1);
  localparam logic [SW-1:0]        R_SQ    = SW'(CORNER_RADIUS * CORNER_RADIUS);

  // configuration registers
  logic [tbpg_pkg::WIDTH_W-1:0] bar_width;
  logic [tbpg_pkg::COLOR_W-1:0] bar_color;
  logic [tbpg_pkg::COLOR_W-1:0] button_color;
  logic [tbpg_pkg::COLOR_W-1:0] mark_color;
  logic                         cfg_wr;
  logic [1:0]                   cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_width    <= tbpg_pkg::RST_BAR_WIDTH;
      bar_color    <= tbpg_pkg::RST_BAR_COLOR;
      button_color <= tbpg_pkg::RST_BUTTON_COLOR;
      mark_color   <= tbpg_pkg::RST_MARK_COLOR;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        tbpg_pkg::REG_BAR_WIDTH:    bar_width    <= pwdata[tbpg_pkg::WIDTH_W-1:0];
        tbpg_pkg::REG_BAR_COLOR:    bar_color    <= pwdata;
        tbpg_pkg::REG_BUTTON_COLOR: button_color <= pwdata;
        tbpg_pkg::REG_MARK_COLOR:   mark_color   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      tbpg_pkg::REG_BAR_WIDTH:
        prdata = {{(tbpg_pkg::APB_W - tbpg_pkg::WIDTH_W){1'b0}}, bar_width};
      tbpg_pkg::REG_BAR_COLOR:    prdata = bar_color;
      tbpg_pkg::REG_BUTTON_COLOR: prdata = button_color;
      tbpg_pkg::REG_MARK_COLOR:   prdata = mark_color;
      default:                    prdata = '0;
    endcase
  end

  // stage flow control
  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  assign adv3     = !v3 || m_tready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign s_tready = adv1;
  assign m_tvalid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= s_tvalid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // stage 1: range check and offset from the right edge
  logic [tbpg_pkg::COL_W-1:0] in_col;
  logic [tbpg_pkg::ROW_W-1:0] in_row;
  logic [tbpg_pkg::COL_W-1:0] x1;
  logic [tbpg_pkg::ROW_W-1:0] y1;
  logic signed [DW-1:0]       xw1;
  logic                       inr1;

  assign in_col = s_tdata[tbpg_pkg::COL_W-1:0];
  assign in_row = s_tdata[tbpg_pkg::COL_W +: tbpg_pkg::ROW_W];

  always_ff @(posedge clk) begin
    if (adv1) begin
      x1   <= in_col;
      y1   <= in_row;
      xw1  <= $signed({{(DW - tbpg_pkg::COL_W){1'b0}}, in_col})
            - $signed({{(DW - tbpg_pkg::WIDTH_W){1'b0}}, bar_width});
      inr1 <= ({1'b0, in_col} < bar_width)
           && ({1'b0, in_row} < (tbpg_pkg::ROW_W + 1)'(BAR_HEIGHT));
    end
  end

  // stage 2: corner distances and close mark test
  logic                 left2, right2;
  logic signed [DW-1:0] x1_s, y1_s, adx_full, ady_full, xr_full;
  logic signed [MW-1:0] xr, ym, nx, ny, da, db;
  logic                 close_c, mark_c, corner_y;
  logic [AW-1:0]        adx2, ady2;
  logic                 zone2, close2, mark2, inr2;

  always_comb begin
    x1_s     = $signed({{(DW - tbpg_pkg::COL_W){1'b0}}, x1});
    y1_s     = $signed({{(DW - tbpg_pkg::ROW_W){1'b0}}, y1});
    left2    = x1_s < R_D;
    right2   = xw1 >= NEG_R;
    corner_y = y1_s < R_D;
    adx_full = left2 ? (R_D - x1_s) : (xw1 + R1_D);
    ady_full = R_D - y1_s;
    xr_full  = xw1 + CW_D;
    close_c  = xr_full >= 0;
    xr       = xr_full[MW-1:0];
    ym       = $signed({{(MW - tbpg_pkg::ROW_W){1'b0}}, y1});
    nx       = xr - MARGIN;
    ny       = ym - MARGIN;
    da       = nx - ny;
    db       = nx + ny - SPAN;
    mark_c   = close_c && (xr >= MARGIN) && (xr < MEND) && (ym >= MARGIN) && (ym < MEND)
            && (((da >= NEG1_M) && (da <= ONE_M)) || ((db >= NEG1_M) && (db <= ONE_M)));
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      adx2   <= adx_full[AW-1:0];
      ady2   <= ady_full[AW-1:0];
      zone2  <= corner_y && (left2 || right2);
      close2 <= close_c;
      mark2  <= mark_c;
      inr2   <= inr1;
    end
  end

  // stage 3: corner circle test and colour select
  logic [SW-1:0]                dist_sq;
  logic                         cut3;
  logic [tbpg_pkg::COLOR_W-1:0] pixel_next;

  always_comb begin
    dist_sq = SW'({{AW{1'b0}}, adx2} * {{AW{1'b0}}, adx2})
            + SW'({{AW{1'b0}}, ady2} * {{AW{1'b0}}, ady2});
    cut3    = zone2 && (dist_sq > R_SQ);
    if (!inr2 || cut3) begin
      pixel_next = tbpg_pkg::TRANSPARENT;
    end else if (mark2) begin
      pixel_next = mark_color;
    end else if (close2) begin
      pixel_next = button_color;
    end else begin
      pixel_next = bar_color;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      m_tdata <= pixel_next;
    end
  end

  // a free receiver always lets the pipeline take a beat
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("s_tready low while m_tready high");

  // with every stage full and the output stalled no beat may enter
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && !m_tready) |-> !s_tready)
    else $error("beat accepted into a full pipeline");

  // a filled stage two moves on whenever stage three is empty
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (v2 && !v3) |=> v3)
    else $error("stage two beat failed to advance");

endmodule
